[src/jpi_pkg.sv]
// ----------------------------------------------------------------------------
// jpi_pkg
// Widths and constants shared by the Jacobian inverse datapath and its
// pipelined divider lanes.
// ----------------------------------------------------------------------------
package jpi_pkg;

    localparam int ENTRY_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int EW    = ENTRY_WIDTH;
    localparam int DIM_W = 2;

    // first level products and sums of three of them
    localparam int PW  = 2 * EW;
    localparam int S1W = 2 * EW + 2;
    // entry times first level sum
    localparam int FPW = 3 * EW + 2;
    // numerators and denominators, signed
    localparam int NW  = 3 * EW + 4;
    localparam int DW  = 4 * EW + 4;

    // scaled dividend and doubled divisor
    localparam int NSH = NW + 2 * FRAC_BITS + 1;
    localparam int NXW = ((NSH > DW) ? NSH : DW) + 1;
    localparam int D2W = DW + 1;

    localparam int LANES  = 9;
    localparam int DIV_ST = EW + 2;
    localparam int NST    = DIV_ST + 7;

endpackage

[src/jpi_div.sv]
// ----------------------------------------------------------------------------
// jpi_div
// One divider lane: rounded, saturated quotient nmag * 2^(2*FRAC_BITS) / dmag,
// one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module jpi_div (
    input  logic                               clk,
    input  logic [jpi_pkg::DIV_ST-1:0]         en,
    input  logic [jpi_pkg::NW-1:0]             nmag,
    input  logic                               neg,
    input  logic [jpi_pkg::DW-1:0]             dmag,
    output logic [jpi_pkg::ENTRY_WIDTH-1:0]    quo
);
    import jpi_pkg::*;

    localparam logic [EW-1:0] LIM_NEG = {1'b1, {(EW-1){1'b0}}};
    localparam logic [EW-1:0] LIM_POS = {1'b0, {(EW-1){1'b1}}};

    logic [D2W-1:0] rem_reg [EW];
    logic [D2W-1:0] d2_reg  [EW];
    logic [EW-1:0]  nlo_reg [EW];
    logic [EW-1:0]  q_reg   [EW];
    logic           neg_reg [EW+1];
    logic           ovf_reg [EW+1];
    logic [EW-1:0]  quo_reg;

    logic [NXW-1:0] nx;
    logic [D2W-1:0] d2;
    logic           ovf0;
    logic [EW-1:0]  qf;
    logic [EW-1:0]  mag;
    logic [EW-1:0]  res;

    // dividend 2*n*2^(2F) + d against divisor 2*d gives round half away
    assign nx   = (NXW'(nmag) << (2 * FRAC_BITS + 1)) + NXW'(dmag);
    assign d2   = {dmag, 1'b0};
    assign ovf0 = NXW'(nx[NXW-1:EW]) >= NXW'(d2);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= D2W'(nx[NXW-1:EW]);
            d2_reg[0]  <= d2;
            nlo_reg[0] <= nx[EW-1:0];
            neg_reg[0] <= neg;
            ovf_reg[0] <= ovf0;
        end
    end

    for (genvar s = 1; s <= EW; s++)
    begin : g_bit
        logic [D2W:0]  trial;
        logic          ge;
        logic [EW-1:0] q_in;

        assign trial = {rem_reg[s-1], nlo_reg[s-1][EW-1]};
        assign ge    = trial >= {1'b0, d2_reg[s-1]};

        if (s == 1)
        begin : g_first
            assign q_in = '0;
        end
        else
        begin : g_rest
            assign q_in = q_reg[s-2];
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                q_reg[s-1] <= {q_in[EW-2:0], ge};
                neg_reg[s] <= neg_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
            end
        end

        if (s < EW)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    rem_reg[s] <= ge ? D2W'(trial - {1'b0, d2_reg[s-1]}) : trial[D2W-1:0];
                    d2_reg[s]  <= d2_reg[s-1];
                    nlo_reg[s] <= nlo_reg[s-1] << 1;
                end
            end
        end
    end

    assign qf = q_reg[EW-1];

    always_comb
    begin
        mag = '0;
        if (neg_reg[EW])
        begin
            mag = (ovf_reg[EW] || qf > LIM_NEG) ? LIM_NEG : qf;
            res = ~mag + 1'b1;
        end
        else
        begin
            res = (ovf_reg[EW] || qf > LIM_POS) ? LIM_POS : qf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[EW+1])
        begin
            quo_reg <= res;
        end
    end

    assign quo = quo_reg;

endmodule

[src/jacobian_pseudoinverse_3x3.sv]
// ----------------------------------------------------------------------------
// jacobian_pseudoinverse_3x3
// Inverse or pseudoinverse of a 3x3 Q16.16 Jacobian, selected by the
// element dimension register.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the element dimension;
//   cfg_ready is always high. Write it only while the block is empty.
//   in channel takes one Jacobian item (nine entries) per handshake.
//   out channel returns one item per input: nine entries and singular.
// Depth: set by the divider lanes, which resolve one quotient bit per stage.
// Throughput: one item per cycle while out_ready is high; every stage holds its own valid bit.
// Stall: when out_ready is low the last stage holds; upstream stages keep
//   filling empty slots, so in_ready stays high until the pipe is full.
// Reset: all valid bits clear, element dimension returns to 3.
// A zero divisor or dimension 0 gives zero entries and singular high.
// ----------------------------------------------------------------------------
module jacobian_pseudoinverse_3x3 (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [jpi_pkg::DIM_W-1:0]               cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [jpi_pkg::ENTRY_WIDTH-1:0]  jac_r0_c0,
    input  logic signed [jpi_pkg::ENTRY_WIDTH-1:0]  jac_r0_c1,
    input  logic signed [jpi_pkg::ENTRY_WIDTH-1:0]  jac_r0_c2,
    input  logic signed [jpi_pkg::ENTRY_WIDTH-1:0]  jac_r1_c0,
    input  logic signed [jpi_pkg::ENTRY_WIDTH-1:0]  jac_r1_c1,
    input  logic signed [jpi_pkg::ENTRY_WIDTH-1:0]  jac_r1_c2,
    input  logic signed [jpi_pkg::ENTRY_WIDTH-1:0]  jac_r2_c0,
    input  logic signed [jpi_pkg::ENTRY_WIDTH-1:0]  jac_r2_c1,
    input  logic signed [jpi_pkg::ENTRY_WIDTH-1:0]  jac_r2_c2,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [jpi_pkg::ENTRY_WIDTH-1:0]  inv_r0_c0,
    output logic signed [jpi_pkg::ENTRY_WIDTH-1:0]  inv_r0_c1,
    output logic signed [jpi_pkg::ENTRY_WIDTH-1:0]  inv_r0_c2,
    output logic signed [jpi_pkg::ENTRY_WIDTH-1:0]  inv_r1_c0,
    output logic signed [jpi_pkg::ENTRY_WIDTH-1:0]  inv_r1_c1,
    output logic signed [jpi_pkg::ENTRY_WIDTH-1:0]  inv_r1_c2,
    output logic signed [jpi_pkg::ENTRY_WIDTH-1:0]  inv_r2_c0,
    output logic signed [jpi_pkg::ENTRY_WIDTH-1:0]  inv_r2_c1,
    output logic signed [jpi_pkg::ENTRY_WIDTH-1:0]  inv_r2_c2,
    output logic                                    singular
);
    import jpi_pkg::*;

    localparam logic [DIM_W-1:0] DIM_NONE  = DIM_W'(0);
    localparam logic [DIM_W-1:0] DIM_ONE   = DIM_W'(1);
    localparam logic [DIM_W-1:0] DIM_TWO   = DIM_W'(2);
    localparam logic [DIM_W-1:0] DIM_THREE = DIM_W'(3);
    localparam int NPROD = 15;

    logic [DIM_W-1:0]     elem_dim_reg;
    logic [NST-1:0]       v_reg;
    logic [NST-1:0]       v_next;
    logic [NST-1:0]       v_shift;
    logic [NST-1:0]       en;

    logic signed [EW-1:0]  jin [3][3];
    logic signed [EW-1:0]  j_reg [6][3][3];
    logic [DIM_W-1:0]      dim_reg [6];

    logic signed [PW-1:0]  pa_reg [3][3];
    logic signed [PW-1:0]  pb_reg [3][3];
    logic signed [PW-1:0]  gp_reg [3][3];

    logic signed [S1W-1:0] cr_reg [4][3][3];
    logic signed [S1W-1:0] msq_reg [4];
    logic signed [S1W-1:0] g11_reg;
    logic signed [S1W-1:0] g01_reg;

    logic signed [EW-1:0]   sj [NPROD];
    logic signed [S1W-1:0]  sx [NPROD];
    logic signed [S1W-1:0]  gx [2];
    logic signed [S1W-1:0]  gy [2];
    logic signed [2*EW:0]   pl_reg [NPROD];
    logic signed [2*EW+1:0] ph_reg [NPROD];
    logic signed [2*EW+3:0] hh_reg [2];
    logic signed [2*EW+2:0] hl_reg [2];
    logic signed [2*EW+2:0] lh_reg [2];
    logic signed [2*EW+1:0] ll_reg [2];

    logic signed [FPW-1:0] fp_reg [NPROD];
    logic signed [DW-1:0]  gg_reg [2];

    logic signed [NW-1:0]  det_reg;
    logic signed [NW-1:0]  nm_reg [3][2];
    logic signed [DW-1:0]  dg_reg;

    logic signed [NW-1:0]  num_s [LANES];
    logic signed [DW-1:0]  den_s;
    logic                  sing_s;
    logic [NW-1:0]         nmag_next [LANES];
    logic                  nneg_next [LANES];
    logic [DW-1:0]         dmag_next;
    logic [NW-1:0]         nmag_reg [LANES];
    logic                  nneg_reg [LANES];
    logic [DW-1:0]         dmag_reg;

    logic [DIV_ST:0]       sing_reg;
    logic [DIV_ST:0]       sing_next;
    logic [EW-1:0]         quo [LANES];

    assign jin[0][0] = jac_r0_c0;
    assign jin[0][1] = jac_r0_c1;
    assign jin[0][2] = jac_r0_c2;
    assign jin[1][0] = jac_r1_c0;
    assign jin[1][1] = jac_r1_c1;
    assign jin[1][2] = jac_r1_c2;
    assign jin[2][0] = jac_r2_c0;
    assign jin[2][1] = jac_r2_c1;
    assign jin[2][2] = jac_r2_c2;

    // stage advances when empty or when the next one advances
    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign v_shift   = {v_reg[NST-2:0], in_valid};
    assign v_next    = (en & v_shift) | (~en & v_reg);
    assign sing_next = (en[NST-1:6] & {sing_reg[DIV_ST-1:0], sing_s})
                     | (~en[NST-1:6] & sing_reg);

    assign in_ready  = en[0];
    assign cfg_ready = 1'b1;
    assign out_valid = v_reg[NST-1];
    assign singular  = sing_reg[DIV_ST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_dim_reg <= DIM_THREE;
            v_reg        <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                elem_dim_reg <= cfg_data;
            end
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sing_reg <= sing_next;
    end

    // second level operand selection: determinant, Gram numerators and Gram divisor terms
    always_comb
    begin
        for (int t = 0; t < 3; t++)
        begin
            sj[t] = j_reg[2][2][t];
            sx[t] = cr_reg[0][2][t];
        end
        for (int r = 0; r < 3; r++)
        begin
            sj[3+4*r]   = j_reg[2][0][r];
            sx[3+4*r]   = g11_reg;
            sj[3+4*r+1] = j_reg[2][1][r];
            sx[3+4*r+1] = g01_reg;
            sj[3+4*r+2] = j_reg[2][1][r];
            sx[3+4*r+2] = msq_reg[0];
            sj[3+4*r+3] = j_reg[2][0][r];
            sx[3+4*r+3] = g01_reg;
        end
        gx[0] = msq_reg[0];
        gy[0] = g11_reg;
        gx[1] = g01_reg;
        gy[1] = g01_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            j_reg[0]   <= jin;
            dim_reg[0] <= elem_dim_reg;
        end
        for (int s = 1; s < 6; s++)
        begin
            if (en[s])
            begin
                j_reg[s]   <= j_reg[s-1];
                dim_reg[s] <= dim_reg[s-1];
            end
        end

        if (en[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pa_reg[k][i] <= j_reg[0][(k+1)%3][(i+1)%3] * j_reg[0][(k+2)%3][(i+2)%3];
                    pb_reg[k][i] <= j_reg[0][(k+1)%3][(i+2)%3] * j_reg[0][(k+2)%3][(i+1)%3];
                end
                gp_reg[0][k] <= j_reg[0][0][k] * j_reg[0][0][k];
                gp_reg[1][k] <= j_reg[0][1][k] * j_reg[0][1][k];
                gp_reg[2][k] <= j_reg[0][0][k] * j_reg[0][1][k];
            end
        end

        if (en[2])
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    cr_reg[0][k][i] <= S1W'(pa_reg[k][i]) - S1W'(pb_reg[k][i]);
                end
            end
            msq_reg[0] <= S1W'(gp_reg[0][0]) + S1W'(gp_reg[0][1]) + S1W'(gp_reg[0][2]);
            g11_reg    <= S1W'(gp_reg[1][0]) + S1W'(gp_reg[1][1]) + S1W'(gp_reg[1][2]);
            g01_reg    <= S1W'(gp_reg[2][0]) + S1W'(gp_reg[2][1]) + S1W'(gp_reg[2][2]);
        end

        for (int s = 3; s < 6; s++)
        begin
            if (en[s])
            begin
                cr_reg[s-2]  <= cr_reg[s-3];
                msq_reg[s-2] <= msq_reg[s-3];
            end
        end

        // split wide operands into a signed high and an unsigned low part
        if (en[3])
        begin
            for (int t = 0; t < NPROD; t++)
            begin
                pl_reg[t] <= sj[t] * $signed({1'b0, sx[t][EW-1:0]});
                ph_reg[t] <= sj[t] * $signed(sx[t][S1W-1:EW]);
            end
            for (int p = 0; p < 2; p++)
            begin
                hh_reg[p] <= $signed(gx[p][S1W-1:EW]) * $signed(gy[p][S1W-1:EW]);
                hl_reg[p] <= $signed(gx[p][S1W-1:EW]) * $signed({1'b0, gy[p][EW-1:0]});
                lh_reg[p] <= $signed({1'b0, gx[p][EW-1:0]}) * $signed(gy[p][S1W-1:EW]);
                ll_reg[p] <= $signed({1'b0, gx[p][EW-1:0]}) * $signed({1'b0, gy[p][EW-1:0]});
            end
        end

        if (en[4])
        begin
            for (int t = 0; t < NPROD; t++)
            begin
                fp_reg[t] <= {ph_reg[t], {EW{1'b0}}} + FPW'(pl_reg[t]);
            end
            for (int p = 0; p < 2; p++)
            begin
                gg_reg[p] <= {hh_reg[p], {(2*EW){1'b0}}}
                           + ((DW'(hl_reg[p]) + DW'(lh_reg[p])) <<< EW)
                           + DW'(ll_reg[p]);
            end
        end

        if (en[5])
        begin
            det_reg <= NW'(fp_reg[0]) + NW'(fp_reg[1]) + NW'(fp_reg[2]);
            for (int r = 0; r < 3; r++)
            begin
                nm_reg[r][0] <= NW'(fp_reg[3+4*r])   - NW'(fp_reg[3+4*r+1]);
                nm_reg[r][1] <= NW'(fp_reg[3+4*r+2]) - NW'(fp_reg[3+4*r+3]);
            end
            dg_reg <= gg_reg[0] - gg_reg[1];
        end

        if (en[6])
        begin
            nmag_reg <= nmag_next;
            nneg_reg <= nneg_next;
            dmag_reg <= dmag_next;
        end
    end

    // per dimension numerator and divisor; zero lanes divide 0 by the shared divisor, or by 1 when singular
    always_comb
    begin
        den_s = '0;
        for (int l = 0; l < LANES; l++)
        begin
            num_s[l] = '0;
        end
        unique case (dim_reg[5])
            DIM_ONE:
            begin
                den_s = DW'(msq_reg[3]);
                for (int r = 0; r < 3; r++)
                begin
                    num_s[r*3] = NW'(j_reg[5][0][r]);
                end
            end
            DIM_TWO:
            begin
                den_s = dg_reg;
                for (int r = 0; r < 3; r++)
                begin
                    num_s[r*3]   = nm_reg[r][0];
                    num_s[r*3+1] = nm_reg[r][1];
                end
            end
            DIM_THREE:
            begin
                den_s = DW'(det_reg);
                for (int r = 0; r < 3; r++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        num_s[r*3+c] = NW'(cr_reg[3][c][r]);
                    end
                end
            end
            DIM_NONE:
            begin
                den_s = '0;
            end
            default:
            begin
                den_s = '0;
            end
        endcase

        sing_s = (den_s == '0);
        for (int l = 0; l < LANES; l++)
        begin
            if (sing_s)
            begin
                nmag_next[l] = '0;
                nneg_next[l] = 1'b0;
            end
            else
            begin
                nmag_next[l] = num_s[l][NW-1] ? (~num_s[l] + 1'b1) : num_s[l];
                nneg_next[l] = num_s[l][NW-1] ^ den_s[DW-1];
            end
        end
        if (sing_s)
        begin
            dmag_next = DW'(1);
        end
        else
        begin
            dmag_next = den_s[DW-1] ? (~den_s + 1'b1) : den_s;
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        jpi_div u_div (
            .clk  (clk),
            .en   (en[NST-1:7]),
            .nmag (nmag_reg[l]),
            .neg  (nneg_reg[l]),
            .dmag (dmag_reg),
            .quo  (quo[l])
        );
    end

    assign inv_r0_c0 = quo[0];
    assign inv_r0_c1 = quo[1];
    assign inv_r0_c2 = quo[2];
    assign inv_r1_c0 = quo[3];
    assign inv_r1_c1 = quo[4];
    assign inv_r1_c2 = quo[5];
    assign inv_r2_c0 = quo[6];
    assign inv_r2_c1 = quo[7];
    assign inv_r2_c2 = quo[8];

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> inv_r0_c0 == '0 && inv_r0_c1 == '0 && inv_r0_c2 == '0
            && inv_r1_c0 == '0 && inv_r1_c1 == '0 && inv_r1_c2 == '0
            && inv_r2_c0 == '0 && inv_r2_c1 == '0 && inv_r2_c2 == '0)
        else $error("singular item with nonzero entries");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[0] |-> in_ready)
        else $error("first stage empty but input blocked");

    a_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[6] && !sing_reg[0] |-> dmag_reg != '0)
        else $error("zero divisor reached divider lanes");

endmodule

[tb/jpi_tb_pkg.sv]
// ----------------------------------------------------------------------------
// jpi_tb_pkg
// Element dimension codes and the matrix item type shared by the testbench
// and its checker.
// ----------------------------------------------------------------------------
package jpi_tb_pkg;

    localparam logic [1:0] DIM_NONE = 2'd0;
    localparam logic [1:0] DIM_LINE = 2'd1;
    localparam logic [1:0] DIM_TRI  = 2'd2;
    localparam logic [1:0] DIM_TET  = 2'd3;

    typedef logic [8:0][jpi_pkg::ENTRY_WIDTH-1:0] matrix_t;

endpackage

[tb/jpi_checker.sv]
// ----------------------------------------------------------------------------
// jpi_checker
// Watches the config, input and output channels, tracks the element
// dimension, computes each expected inverse with exact wide integers and
// compares every returned item entry by entry in order.
// ----------------------------------------------------------------------------
module jpi_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [jpi_pkg::DIM_W-1:0] cfg_data,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  jpi_tb_pkg::matrix_t       jac,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  jpi_tb_pkg::matrix_t       inv,
    input  logic                      singular,
    output int                        errors,
    output int                        pending
);
    import jpi_pkg::*;
    import jpi_tb_pkg::*;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        matrix_t ent;
        logic    sing;
    } inverse_t;

    localparam wide_t LIM = wide_t'(1) <<< (ENTRY_WIDTH - 1);

    inverse_t         inverse_q[$];
    logic [DIM_W-1:0] dim;

    // num * 2^(2F) / den, rounded half away from zero, saturated
    function automatic logic [ENTRY_WIDTH-1:0] fx_quot(input wide_t num, input wide_t den);
        wide_t an;
        wide_t ad;
        wide_t q;
        logic  neg;
        neg = (num < 0) ^ (den < 0);
        an  = (num < 0) ? -num : num;
        ad  = (den < 0) ? -den : den;
        q   = ((an <<< (2 * FRAC_BITS + 1)) + ad) / (ad <<< 1);
        if (neg)
        begin
            if (q > LIM)
                q = LIM;
            q = -q;
        end
        else if (q > LIM - 1)
            q = LIM - 1;
        return q[ENTRY_WIDTH-1:0];
    endfunction

    function automatic inverse_t jacobian_inverse(input matrix_t j, input logic [DIM_W-1:0] d);
        wide_t    m [3][3];
        wide_t    cr [3][3];
        wide_t    g00;
        wide_t    g01;
        wide_t    g11;
        wide_t    den;
        wide_t    nm;
        inverse_t res;
        int       p;
        int       s;
        res = '0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                m[r][c] = wide_t'($signed(j[r*3+c]));
        case (d)
            DIM_LINE:
            begin
                den = m[0][0]*m[0][0] + m[0][1]*m[0][1] + m[0][2]*m[0][2];
                if (den == 0)
                    res.sing = 1'b1;
                else
                    for (int r = 0; r < 3; r++)
                        res.ent[r*3] = fx_quot(m[0][r], den);
            end
            DIM_TRI:
            begin
                g00 = m[0][0]*m[0][0] + m[0][1]*m[0][1] + m[0][2]*m[0][2];
                g01 = m[0][0]*m[1][0] + m[0][1]*m[1][1] + m[0][2]*m[1][2];
                g11 = m[1][0]*m[1][0] + m[1][1]*m[1][1] + m[1][2]*m[1][2];
                den = g00*g11 - g01*g01;
                if (den == 0)
                    res.sing = 1'b1;
                else
                    for (int r = 0; r < 3; r++)
                    begin
                        nm = m[0][r]*g11 - m[1][r]*g01;
                        res.ent[r*3] = fx_quot(nm, den);
                        nm = m[1][r]*g00 - m[0][r]*g01;
                        res.ent[r*3+1] = fx_quot(nm, den);
                    end
            end
            DIM_TET:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    p = (k + 1) % 3;
                    s = (k + 2) % 3;
                    cr[k][0] = m[p][1]*m[s][2] - m[p][2]*m[s][1];
                    cr[k][1] = m[p][2]*m[s][0] - m[p][0]*m[s][2];
                    cr[k][2] = m[p][0]*m[s][1] - m[p][1]*m[s][0];
                end
                den = m[2][0]*cr[2][0] + m[2][1]*cr[2][1] + m[2][2]*cr[2][2];
                if (den == 0)
                    res.sing = 1'b1;
                else
                    for (int r = 0; r < 3; r++)
                        for (int c = 0; c < 3; c++)
                            res.ent[r*3+c] = fx_quot(cr[c][r], den);
            end
            default:
                res.sing = 1'b1;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        inverse_t want;
        if (!rst_n)
        begin
            dim = DIM_TET;
            inverse_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                dim = cfg_data;
            if (in_valid && in_ready)
                inverse_q.push_back(jacobian_inverse(jac, dim));
            if (out_valid && out_ready)
            begin
                if (inverse_q.size() == 0)
                begin
                    $display("%0t: unexpected item on output", $time);
                    errors++;
                end
                else
                begin
                    want = inverse_q.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (inv[k] !== want.ent[k])
                        begin
                            $display("%0t: inv_r%0d_c%0d expected %h actual %h",
                                     $time, k / 3, k % 3, want.ent[k], inv[k]);
                            errors++;
                        end
                    if (singular !== want.sing)
                    begin
                        $display("%0t: singular expected %b actual %b",
                                 $time, want.sing, singular);
                        errors++;
                    end
                end
            end
            pending = inverse_q.size();
        end
    end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives jacobian_pseudoinverse_3x3 through every element dimension with
// directed corner matrices and random ones (full range, small, well
// conditioned, singular), random gaps and stalls on both channels, a long
// output hold-off and a full drain; jpi_checker does the comparison.
// ----------------------------------------------------------------------------
module tb_top;

    import jpi_pkg::*;
    import jpi_tb_pkg::*;

    localparam int PHASE_ITEMS = 225;
    localparam int IDLE_LIMIT  = 3000;

    logic             clk;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [DIM_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_ready;
    matrix_t          jac;
    logic             out_valid;
    logic             out_ready;
    matrix_t          inv;
    logic             singular;
    int               errors;
    int               pending;
    int               idle_cycles;
    int               hold_requests;
    bit               no_gaps;

    jacobian_pseudoinverse_3x3 uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .jac_r0_c0 (jac[0]),
        .jac_r0_c1 (jac[1]),
        .jac_r0_c2 (jac[2]),
        .jac_r1_c0 (jac[3]),
        .jac_r1_c1 (jac[4]),
        .jac_r1_c2 (jac[5]),
        .jac_r2_c0 (jac[6]),
        .jac_r2_c1 (jac[7]),
        .jac_r2_c2 (jac[8]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .inv_r0_c0 (inv[0]),
        .inv_r0_c1 (inv[1]),
        .inv_r0_c2 (inv[2]),
        .inv_r1_c0 (inv[3]),
        .inv_r1_c1 (inv[4]),
        .inv_r1_c2 (inv[5]),
        .inv_r2_c0 (inv[6]),
        .inv_r2_c1 (inv[7]),
        .inv_r2_c2 (inv[8]),
        .singular  (singular)
    );

    jpi_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .jac       (jac),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .inv       (inv),
        .singular  (singular),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [31:0] extreme_entry();
        case ($urandom_range(0, 6))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'h0000_0001;
            4: return 32'hffff_ffff;
            5: return 32'h0001_0000;
            default: return 32'hffff_0000;
        endcase
    endfunction

    function automatic logic [31:0] small_entry(input int span);
        return 32'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic matrix_t random_matrix();
        matrix_t m;
        int      k;
        k = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++)
            case (k)
                0:       m[i] = $urandom;
                1, 2:    m[i] = small_entry(1 << 18);
                3:       m[i] = extreme_entry();
                4:       m[i] = ($urandom >> $urandom_range(0, 31))
                                ^ ({32{$urandom_range(0, 1) == 1}});
                default:
                    if (i % 4 == 0)
                        m[i] = ($urandom_range(0, 1) == 1)
                               ? 32'($urandom_range(32'h8000, 32'h40000))
                               : -32'($urandom_range(32'h8000, 32'h40000));
                    else
                        m[i] = small_entry(32'h4000);
            endcase
        if (k == 8)
            for (int c = 0; c < 3; c++)
            begin
                if ($urandom_range(0, 1) == 1)
                    m[6+c] = m[c] + m[3+c];
                else
                    m[3+c] = m[c] <<< $urandom_range(0, 2);
            end
        if (k == 9 && $urandom_range(0, 2) == 0)
            for (int c = 0; c < 3; c++)
                m[c] = '0;
        return m;
    endfunction

    function automatic matrix_t corner_matrix(input int n);
        matrix_t m;
        for (int i = 0; i < 9; i++)
            case (n)
                0: m[i] = '0;
                1: m[i] = (i % 4 == 0) ? 32'h0001_0000 : 32'h0;
                2: m[i] = 32'h7fff_ffff;
                3: m[i] = 32'h8000_0000;
                4: m[i] = (i % 4 == 0) ? 32'h0000_0001 : 32'h0;
                5: m[i] = (i % 4 == 0) ? ((i == 4) ? 32'h8000_0000 : 32'h7fff_ffff) : 32'h0;
                6: m[i] = (i % 2 == 1) ? 32'hffff_ffff : 32'h0;
                default: m[i] = (i < 6) ? 32'h0002_0000 : 32'h0001_0000;
            endcase
        return m;
    endfunction

    task automatic send_item(input matrix_t m);
        int gap;
        gap = 0;
        if (!no_gaps)
        begin
            gap = $urandom_range(0, 99);
            gap = (gap < 60) ? 0 : (gap < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        jac      = m;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    task automatic write_dim(input logic [DIM_W-1:0] d);
        cfg_data  = d;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // receiver: random ready with short and long stalls, plus requested hold-offs
    initial
    begin
        int stall_left;
        int run_left;
        int holds_done;
        stall_left = 0;
        run_left   = 0;
        holds_done = 0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_requests > holds_done)
            begin
                holds_done++;
                stall_left = 300;
                run_left   = 0;
            end
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else if (run_left > 0)
            begin
                out_ready = 1'b1;
                run_left--;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_ready  = 1'b0;
                stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 3)
                                                        : $urandom_range(20, 60);
            end
            else
            begin
                out_ready = 1'b1;
                run_left  = $urandom_range(0, 40);
            end
        end
    end

    initial
    begin
        logic [DIM_W-1:0] dims [8];
        dims = '{DIM_TET, DIM_LINE, DIM_TRI, DIM_NONE, DIM_TET, DIM_TRI, DIM_LINE, DIM_TET};
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        jac           = '0;
        hold_requests = 0;
        no_gaps       = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                write_dim(dims[ph]);
            end
            if (ph < 3)
                for (int n = 0; n < 8; n++)
                    send_item(corner_matrix(n));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 50 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                if (ph == 2 && i == 40)
                begin
                    no_gaps = 1'b1;
                    hold_requests++;
                end
                if (ph == 4 && i == 120)
                    drain();
                send_item(random_matrix());
            end
        end
        drain();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[jacobian_pseudoinverse_3x3.f]
src/jpi_pkg.sv
src/jpi_div.sv
src/jacobian_pseudoinverse_3x3.sv
tb/jpi_tb_pkg.sv
tb/jpi_checker.sv
tb/tb_top.sv
